/* hw/rtl/wtosc_pkg.sv */
`timescale 1ns / 1ps
package wtosc_pkg;

   // defaults for the top level parameters
   localparam int TABLE_BITS_DEF    = 13;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int SINE_ROM_BITS_DEF = 10;

   // register file
   localparam int LEN_BITS       = 25;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_MODE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_LENGTH = CSR_INDEX_BITS'(1);

   localparam logic [MODE_BITS-1:0] FADE_NONE   = MODE_BITS'(0);
   localparam logic [MODE_BITS-1:0] FADE_LINEAR = MODE_BITS'(1);
   localparam logic [MODE_BITS-1:0] FADE_POWER  = MODE_BITS'(2);

   localparam logic [MODE_BITS-1:0] FADE_MODE_RESET   = FADE_LINEAR;
   localparam logic [LEN_BITS-1:0]  FADE_LENGTH_RESET = LEN_BITS'(48000);

   // fade fraction and sine values are unsigned Q.16, unity needs one more bit
   localparam int LIN_FRAC_BITS = 16;
   localparam int UNITY_W       = LIN_FRAC_BITS + 1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_BEGIN = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_POW1,
      S_POW2,
      S_POW3,
      S_SUM,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_OLD,
      KIND_NEW,
      KIND_LIN,
      KIND_POW
   } kind_type;

   // odd polynomial coefficients for sin(pi/2 * t), Q.30
   localparam longint Q30_C1  = 1686629713;
   localparam longint Q30_C3  = 693598668;
   localparam longint Q30_C5  = 85569305;
   localparam longint Q30_C7  = 5026995;
   localparam longint Q30_C9  = 172272;
   localparam longint Q30_C11 = 3864;

   // quarter-wave sine entry k of a 2^rom_bits table, unsigned Q.16
   function automatic logic [UNITY_W-1:0] sine_entry(input int k, input int rom_bits);
      longint t;
      longint t2;
      longint p;
      longint s;
      t  = longint'(k) <<< (30 - rom_bits);
      t2 = (t * t) >>> 30;
      p  = -Q30_C11;
      p  = Q30_C9 + ((p * t2) >>> 30);
      p  = -Q30_C7 + ((p * t2) >>> 30);
      p  = Q30_C5 + ((p * t2) >>> 30);
      p  = -Q30_C3 + ((p * t2) >>> 30);
      p  = Q30_C1 + ((p * t2) >>> 30);
      s  = (p * t) >>> 30;
      if (s < 0) begin
         s = 0;
      end
      return UNITY_W'((s + 8192) >>> 14);
   endfunction

endpackage

/* hw/rtl/wavetable_oscillator_crossfade_top.sv */
`timescale 1ns / 1ps
// Two-bank wavetable oscillator with crossfade. A tick request reads both banks at the
// truncated phase and returns one sample; begin, write and end requests load the idle bank and
// return nothing. A tick during a fade runs the fade fraction through a shared divider that
// yields one quotient bit per cycle, and an equal-power tick adds two sine ROM reads and a
// second pass through the one multiplier. A new request is taken while the previous sample
// still waits on the response side. The configuration port is always ready; write it only
// while no request is in flight.
module wavetable_oscillator_crossfade_top #(
   parameter int TABLE_BITS    = wtosc_pkg::TABLE_BITS_DEF,
   parameter int FRAC_BITS     = wtosc_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_BITS   = wtosc_pkg::SAMPLE_BITS_DEF,
   parameter int SINE_ROM_BITS = wtosc_pkg::SINE_ROM_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_cmd,
   input  logic signed [TABLE_BITS+FRAC_BITS-1:0]    req_phase_step,
   input  logic [TABLE_BITS-1:0]                     req_entry_index,
   input  logic signed [SAMPLE_BITS-1:0]             req_entry_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]             rsp_sample,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [wtosc_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [wtosc_pkg::LEN_BITS-1:0]            csr_wdata
);

   localparam int PHASE_W = TABLE_BITS + FRAC_BITS;
   localparam int LB      = wtosc_pkg::LEN_BITS;
   localparam int MB      = wtosc_pkg::MODE_BITS;
   localparam int UW      = wtosc_pkg::UNITY_W;
   localparam int QB      = wtosc_pkg::LIN_FRAC_BITS;
   localparam int ACC_W   = UW + 1 + SAMPLE_BITS + 1;
   localparam int R       = SINE_ROM_BITS;

   localparam logic [UW-1:0]           UNITY   = UW'(1) << QB;
   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (QB - 1);
   localparam logic signed [ACC_W-1:0] SMP_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

   wtosc_pkg::state_type  state_ff, state_in;
   wtosc_pkg::kind_type   kind_ff,  kind_in;
   logic                  active_ff,   active_in;
   logic                  updating_ff, updating_in;
   logic                  loaded_ff,   loaded_in;
   logic [PHASE_W-1:0]    phase_ff,    phase_in;
   logic [LB-1:0]         count_ff,    count_in;
   logic [MB-1:0]         mode_ff,     mode_in;
   logic [LB-1:0]         length_ff,   length_in;
   logic [R:0]            k_ff,        k_in;
   logic signed [ACC_W-1:0] acc_ff,    acc_in;
   logic signed [ACC_W-1:0] prod_ff,   prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;

   logic                  req_accept;
   logic                  tick_accept;
   logic                  bank_we;
   logic [SAMPLE_BITS-1:0] rd_a, rd_b;
   logic signed [SAMPLE_BITS-1:0] nv, ov;
   logic                  div_start, div_done;
   logic [UW-1:0]         div_quot;
   logic [R-1:0]          rom_addr;
   logic [UW-1:0]         rom_data;
   logic [UW-1:0]         sine_v;
   logic signed [UW:0]    mul_a;
   logic signed [SAMPLE_BITS:0] mul_b;
   logic signed [ACC_W-1:0] mul_p;
   logic signed [ACC_W-1:0] rnd, shr;
   logic signed [SAMPLE_BITS-1:0] mix_v;

   assign req_ready   = (state_ff == wtosc_pkg::S_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign tick_accept = req_accept && (req_cmd == wtosc_pkg::CMD_TICK);
   assign bank_we     = req_accept && (req_cmd == wtosc_pkg::CMD_WRITE) && updating_ff;
   assign csr_ready   = 1'b1;

   // active bank holds the newest table
   wtosc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(1 << TABLE_BITS)) u_bank_a (
      .clock   (clock),
      .wr_en   (bank_we && !active_ff),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_value),
      .rd_en   (tick_accept),
      .rd_addr (phase_ff[PHASE_W-1:FRAC_BITS]),
      .rd_data (rd_a)
   );

   wtosc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(1 << TABLE_BITS)) u_bank_b (
      .clock   (clock),
      .wr_en   (bank_we && active_ff),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_value),
      .rd_en   (tick_accept),
      .rd_addr (phase_ff[PHASE_W-1:FRAC_BITS]),
      .rd_data (rd_b)
   );

   assign nv = active_ff ? signed'(rd_b) : signed'(rd_a);
   assign ov = active_ff ? signed'(rd_a) : signed'(rd_b);

   wtosc_frac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .count  (count_ff),
      .length (length_ff),
      .done   (div_done),
      .quot   (div_quot)
   );

   wtosc_sine_rom #(.ROM_BITS(R)) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign mul_p = mul_a * mul_b;

   // rounded Q.16 mix, saturated
   assign rnd = acc_ff + HALF;
   assign shr = rnd >>> QB;
   always_comb begin
      if (shr > SMP_MAX) begin
         mix_v = SMP_MAX[SAMPLE_BITS-1:0];
      end else if (shr < SMP_MIN) begin
         mix_v = SMP_MIN[SAMPLE_BITS-1:0];
      end else begin
         mix_v = shr[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      active_in     = active_ff;
      updating_in   = updating_ff;
      loaded_in     = loaded_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      length_in     = length_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      div_start     = 1'b0;
      rom_addr      = k_ff[R-1:0];
      sine_v        = rom_data;
      mul_a         = signed'({1'b0, div_quot});
      mul_b         = (SAMPLE_BITS + 1)'(ov) - (SAMPLE_BITS + 1)'(nv);

      if (csr_valid) begin
         unique case (csr_index)
            wtosc_pkg::CSR_FADE_MODE:   mode_in   = csr_wdata[MB-1:0];
            wtosc_pkg::CSR_FADE_LENGTH: length_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         wtosc_pkg::S_IDLE: begin
            if (req_accept) begin
               unique case (wtosc_pkg::cmd_type'(req_cmd))
                  wtosc_pkg::CMD_BEGIN: begin
                     if (!updating_ff) begin
                        active_in   = !active_ff;
                        updating_in = 1'b1;
                     end
                  end
                  wtosc_pkg::CMD_WRITE: ;
                  wtosc_pkg::CMD_END: begin
                     if (updating_ff) begin
                        updating_in = 1'b0;
                        if (!loaded_ff) begin
                           loaded_in = 1'b1;
                           count_in  = '0;
                        end else if (mode_ff == wtosc_pkg::FADE_LINEAR ||
                                     mode_ff == wtosc_pkg::FADE_POWER) begin
                           count_in = length_ff;
                        end else begin
                           count_in = '0;
                        end
                     end
                  end
                  wtosc_pkg::CMD_TICK: begin
                     phase_in = phase_ff + $unsigned(req_phase_step);
                     state_in = wtosc_pkg::S_OUT;
                     if (!loaded_ff) begin
                        kind_in = wtosc_pkg::KIND_ZERO;
                     end else if (updating_ff) begin
                        kind_in = wtosc_pkg::KIND_OLD;
                     end else if (count_ff != '0) begin
                        count_in = count_ff - LB'(1);
                        if (mode_ff == wtosc_pkg::FADE_LINEAR) begin
                           kind_in   = wtosc_pkg::KIND_LIN;
                           div_start = 1'b1;
                           state_in  = wtosc_pkg::S_DIV;
                        end else if (mode_ff == wtosc_pkg::FADE_POWER) begin
                           kind_in   = wtosc_pkg::KIND_POW;
                           div_start = 1'b1;
                           state_in  = wtosc_pkg::S_DIV;
                        end else begin
                           kind_in = wtosc_pkg::KIND_NEW;
                        end
                     end else begin
                        kind_in = wtosc_pkg::KIND_NEW;
                     end
                  end
               endcase
            end
         end
         wtosc_pkg::S_DIV: begin
            if (div_done) begin
               if (kind_ff == wtosc_pkg::KIND_LIN) begin
                  // new * unity + f * (old - new)
                  acc_in   = ACC_W'(nv) <<< QB;
                  prod_in  = mul_p;
                  state_in = wtosc_pkg::S_SUM;
               end else begin
                  k_in     = (R + 1)'(div_quot >> (QB - R));
                  state_in = wtosc_pkg::S_POW1;
               end
            end
         end
         wtosc_pkg::S_POW1: begin
            state_in = wtosc_pkg::S_POW2;
         end
         wtosc_pkg::S_POW2: begin
            // sine at k, then look up cosine as sine at full scale minus k
            sine_v   = k_ff[R] ? UNITY : rom_data;
            mul_a    = signed'({1'b0, sine_v});
            mul_b    = (SAMPLE_BITS + 1)'(ov);
            prod_in  = mul_p;
            rom_addr = R'(-k_ff);
            state_in = wtosc_pkg::S_POW3;
         end
         wtosc_pkg::S_POW3: begin
            sine_v   = (k_ff == '0) ? UNITY : rom_data;
            mul_a    = signed'({1'b0, sine_v});
            mul_b    = (SAMPLE_BITS + 1)'(nv);
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = wtosc_pkg::S_SUM;
         end
         wtosc_pkg::S_SUM: begin
            acc_in   = acc_ff + prod_ff;
            state_in = wtosc_pkg::S_OUT;
         end
         wtosc_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               unique case (kind_ff)
                  wtosc_pkg::KIND_ZERO: rsp_sample_in = '0;
                  wtosc_pkg::KIND_OLD:  rsp_sample_in = ov;
                  wtosc_pkg::KIND_NEW:  rsp_sample_in = nv;
                  wtosc_pkg::KIND_LIN,
                  wtosc_pkg::KIND_POW:  rsp_sample_in = mix_v;
                  default:              rsp_sample_in = '0;
               endcase
               state_in = wtosc_pkg::S_IDLE;
            end
         end
         default: state_in = wtosc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wtosc_pkg::S_IDLE;
         kind_ff      <= wtosc_pkg::KIND_ZERO;
         active_ff    <= 1'b0;
         updating_ff  <= 1'b0;
         loaded_ff    <= 1'b0;
         phase_ff     <= '0;
         count_ff     <= '0;
         mode_ff      <= wtosc_pkg::FADE_MODE_RESET;
         length_ff    <= wtosc_pkg::FADE_LENGTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         active_ff    <= active_in;
         updating_ff  <= updating_in;
         loaded_ff    <= loaded_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == wtosc_pkg::S_DIV)
      else $error("fraction divider finished outside the divide state");

   a_fade_countdown: assert property (@(posedge clock) disable iff (reset)
      (tick_accept && loaded_ff && !updating_ff && count_ff != '0)
      |=> count_ff == $past(count_ff) - LB'(1))
      else $error("fade count did not step down on a fading tick");

   a_no_fade_before_load: assert property (@(posedge clock) disable iff (reset)
      !loaded_ff |-> count_ff == '0)
      else $error("fade pending before the first table load");

   a_phase_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !tick_accept |=> $stable(phase_ff))
      else $error("phase moved without a tick request");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == wtosc_pkg::S_OUT)
      else $error("response raised outside the output state");

endmodule

/* hw/rtl/wtosc_ram.sv */
`timescale 1ns / 1ps
module wtosc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/wtosc_sine_rom.sv */
`timescale 1ns / 1ps
module wtosc_sine_rom #(
   parameter int ROM_BITS = wtosc_pkg::SINE_ROM_BITS_DEF
) (
   input  logic                           clock,
   input  logic [ROM_BITS-1:0]            addr,
   output logic [wtosc_pkg::UNITY_W-1:0]  data
);

   localparam int ROM_SIZE = 1 << ROM_BITS;

   logic [wtosc_pkg::UNITY_W-1:0] rom_word [ROM_SIZE];
   logic [wtosc_pkg::UNITY_W-1:0] data_ff;

   for (genvar k = 0; k < ROM_SIZE; k++) begin : g_word
      assign rom_word[k] = wtosc_pkg::sine_entry(k, ROM_BITS);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_word[addr];
   end

   assign data = data_ff;

endmodule

/* hw/rtl/wtosc_frac_div.sv */
`timescale 1ns / 1ps
// floor(count * 2^16 / length), one quotient bit per cycle,
// saturating at 2^16 when length is zero or not above count
module wtosc_frac_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wtosc_pkg::LEN_BITS-1:0]      count,
   input  logic [wtosc_pkg::LEN_BITS-1:0]      length,
   output logic                                done,
   output logic [wtosc_pkg::UNITY_W-1:0]       quot
);

   localparam int LB = wtosc_pkg::LEN_BITS;
   localparam int QB = wtosc_pkg::LIN_FRAC_BITS;
   localparam int CW = $clog2(QB + 1);

   logic                 run_ff,  run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff,  cnt_in;
   logic [LB-1:0]        rem_ff,  rem_in;
   logic [QB:0]          quot_ff, quot_in;
   logic [LB:0]          rem2;
   logic                 qbit;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      rem2    = {rem_ff, 1'b0};
      qbit    = (rem2 >= {1'b0, length});
      if (start) begin
         if (length == '0 || count >= length) begin
            quot_in = (QB + 1)'(1) << QB;
            done_in = 1'b1;
         end else begin
            rem_in  = count;
            quot_in = '0;
            cnt_in  = CW'(QB);
            run_in  = 1'b1;
         end
      end else if (run_ff) begin
         // remainder stays below length, so the difference fits LB bits
         rem_in  = qbit ? LB'(rem2 - {1'b0, length}) : LB'(rem2);
         quot_in = {quot_ff[QB-1:0], qbit};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

/* dv/wavetable_oscillator_crossfade_top_tb.sv */
`timescale 1ns / 1ps
module wavetable_oscillator_crossfade_top_tb;

   localparam int TBITS     = wtosc_pkg::TABLE_BITS_DEF;
   localparam int FBITS     = wtosc_pkg::FRAC_BITS_DEF;
   localparam int SBITS     = wtosc_pkg::SAMPLE_BITS_DEF;
   localparam int RBITS     = wtosc_pkg::SINE_ROM_BITS_DEF;
   localparam int LBITS     = wtosc_pkg::LEN_BITS;
   localparam int PBITS     = TBITS + FBITS;
   localparam int TABLE_LEN = 1 << TBITS;
   localparam int ROM_LEN   = 1 << RBITS;
   localparam int SETTLE    = 48;

   localparam longint UNITY  = 65536;
   localparam longint SMP_HI = (longint'(1) << (SBITS - 1)) - 1;
   localparam longint SMP_LO = -(longint'(1) << (SBITS - 1));

   localparam logic [1:0]        FADE_CODE3  = 2'd3;
   localparam logic [LBITS-1:0]  LEN_MAX     = '1;
   localparam logic signed [PBITS-1:0] STEP_MAX = {1'b0, {(PBITS - 1){1'b1}}};
   localparam logic [PBITS-1:0]  STEP_BANNED = {1'b1, {(PBITS - 1){1'b0}}};

   // sin(pi/2 * t) odd polynomial, Q.30
   localparam longint SIN_C1  = 1686629713;
   localparam longint SIN_C3  = 693598668;
   localparam longint SIN_C5  = 85569305;
   localparam longint SIN_C7  = 5026995;
   localparam longint SIN_C9  = 172272;
   localparam longint SIN_C11 = 3864;

   logic                                    clock;
   logic                                    reset;
   logic                                    req_valid;
   logic                                    req_ready;
   logic [1:0]                              req_cmd;
   logic signed [PBITS-1:0]                 req_phase_step;
   logic [TBITS-1:0]                        req_entry_index;
   logic signed [SBITS-1:0]                 req_entry_value;
   logic                                    rsp_valid;
   logic                                    rsp_ready;
   logic signed [SBITS-1:0]                 rsp_sample;
   logic                                    csr_valid;
   logic                                    csr_ready;
   logic [wtosc_pkg::CSR_INDEX_BITS-1:0]    csr_index;
   logic [LBITS-1:0]                        csr_wdata;

   // oscillator state as the testbench sees it
   logic signed [SBITS-1:0] bank_mem [0:1][0:TABLE_LEN-1];
   bit                      written  [0:1][0:TABLE_LEN-1];
   int                      both_q[$];
   int                      one_q[$];
   int                      osc_active;
   bit                      osc_updating;
   bit                      osc_loaded;
   logic [PBITS-1:0]        osc_phase;
   logic [LBITS-1:0]        osc_count;
   logic [1:0]              cfg_mode;
   logic [LBITS-1:0]        cfg_length;
   longint                  sine_rom [0:ROM_LEN-1];

   logic signed [SBITS-1:0] pending_samples[$];
   int                      mismatches;
   int                      hold_cycles;
   bit                      tx_burst;
   bit                      rx_burst;

   wavetable_oscillator_crossfade_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_phase_step  (req_phase_step),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint quarter_sine(input int k);
      longint t;
      longint t2;
      longint p;
      longint s;
      t  = longint'(k) <<< (30 - RBITS);
      t2 = (t * t) >>> 30;
      p  = -SIN_C11;
      p  = SIN_C9 + ((p * t2) >>> 30);
      p  = -SIN_C7 + ((p * t2) >>> 30);
      p  = SIN_C5 + ((p * t2) >>> 30);
      p  = -SIN_C3 + ((p * t2) >>> 30);
      p  = SIN_C1 + ((p * t2) >>> 30);
      s  = (p * t) >>> 30;
      if (s < 0) begin
         s = 0;
      end
      return (s + 8192) >>> 14;
   endfunction

   function automatic longint sine_at(input longint k);
      if (k >= ROM_LEN) begin
         return UNITY;
      end
      return sine_rom[k];
   endfunction

   // count / length in Q.bits, saturating at one
   function automatic longint fade_fraction(input int bits);
      longint one;
      longint q;
      one = longint'(1) << bits;
      if (cfg_length == 0 || osc_count >= cfg_length) begin
         return one;
      end
      q = (longint'(osc_count) << bits) / longint'(cfg_length);
      return (q > one) ? one : q;
   endfunction

   task automatic advance_oscillator(input logic [1:0] cmd,
                                     input logic signed [PBITS-1:0] step,
                                     input logic [TBITS-1:0] idx,
                                     input logic signed [SBITS-1:0] val);
      int     fresh;
      int     i;
      longint nv;
      longint ov;
      longint res;
      longint f;
      longint k;
      fresh = osc_active;
      case (cmd)
         wtosc_pkg::CMD_BEGIN: begin
            if (!osc_updating) begin
               osc_active   = 1 - osc_active;
               osc_updating = 1'b1;
            end
         end
         wtosc_pkg::CMD_WRITE: begin
            if (osc_updating) begin
               bank_mem[fresh][idx] = val;
               if (!written[fresh][idx]) begin
                  written[fresh][idx] = 1'b1;
                  if (written[1 - fresh][idx]) begin
                     both_q.push_back(int'(idx));
                  end else begin
                     one_q.push_back(int'(idx));
                  end
               end
            end
         end
         wtosc_pkg::CMD_END: begin
            if (osc_updating) begin
               osc_updating = 1'b0;
               if (!osc_loaded) begin
                  osc_loaded = 1'b1;
                  osc_count  = '0;
               end else if (cfg_mode == wtosc_pkg::FADE_LINEAR ||
                            cfg_mode == wtosc_pkg::FADE_POWER) begin
                  osc_count = cfg_length;
               end else begin
                  osc_count = '0;
               end
            end
         end
         default: begin
            i  = int'(osc_phase[PBITS-1:FBITS]);
            nv = bank_mem[fresh][i];
            ov = bank_mem[1 - fresh][i];
            if (!osc_loaded) begin
               res = 0;
            end else if (osc_updating) begin
               res = ov;
            end else if (osc_count != 0) begin
               if (cfg_mode == wtosc_pkg::FADE_LINEAR) begin
                  f   = fade_fraction(wtosc_pkg::LIN_FRAC_BITS);
                  res = nv + ((f * (ov - nv) + 32768) >>> 16);
               end else if (cfg_mode == wtosc_pkg::FADE_POWER) begin
                  k   = fade_fraction(RBITS);
                  res = (sine_at(k) * ov + sine_at(ROM_LEN - k) * nv + 32768) >>> 16;
               end else begin
                  res = nv;
               end
               osc_count = osc_count - 1'b1;
            end else begin
               res = nv;
            end
            osc_phase = osc_phase + step;
            if (res > SMP_HI) begin
               res = SMP_HI;
            end else if (res < SMP_LO) begin
               res = SMP_LO;
            end
            pending_samples.push_back(SBITS'(res));
         end
      endcase
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      if (tx_burst) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PBITS-1:0] junk_step();
      logic [PBITS-1:0] s;
      s = PBITS'($urandom);
      if (s == STEP_BANNED) begin
         s = '0;
      end
      return s;
   endfunction

   // valid stays up across back-to-back requests, it only drops for a gap
   task automatic send_request(input logic [1:0] cmd,
                               input logic signed [PBITS-1:0] step,
                               input logic [TBITS-1:0] idx,
                               input logic signed [SBITS-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_phase_step  <= step;
      req_entry_index <= idx;
      req_entry_value <= val;
      advance_oscillator(cmd, step, idx, val);
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_cmd(input logic [1:0] cmd);
      send_request(cmd, junk_step(), TBITS'($urandom), SBITS'($urandom));
   endtask

   task automatic send_write(input int idx, input int val);
      send_request(wtosc_pkg::CMD_WRITE, junk_step(), TBITS'(idx), SBITS'(val));
   endtask

   // step chosen so that the next tick lands on table position idx
   task automatic send_tick_to(input int idx);
      logic [PBITS-1:0] target;
      logic [PBITS-1:0] d;
      target = {idx[TBITS-1:0], FBITS'($urandom)};
      d      = target - osc_phase;
      if (d == STEP_BANNED) begin
         target[0] = ~target[0];
         d         = target - osc_phase;
      end
      send_request(wtosc_pkg::CMD_TICK, d, TBITS'($urandom), SBITS'($urandom));
   endtask

   // steers to a position loaded in both banks if any, else in one bank, else position 0
   task automatic send_tick();
      if (both_q.size() > 0) begin
         send_tick_to(both_q[$urandom_range(0, both_q.size() - 1)]);
      end else if (one_q.size() > 0) begin
         send_tick_to(one_q[$urandom_range(0, one_q.size() - 1)]);
      end else begin
         send_tick_to(0);
      end
   endtask

   function automatic int pick_write_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50 && one_q.size() > 0) begin
         return one_q[$urandom_range(0, one_q.size() - 1)];
      end
      if (r < 65 && both_q.size() > 0) begin
         return both_q[$urandom_range(0, both_q.size() - 1)];
      end
      return $urandom_range(0, TABLE_LEN - 1);
   endfunction

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wtosc_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [LBITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == wtosc_pkg::CSR_FADE_MODE) begin
         cfg_mode = data[1:0];
      end else begin
         cfg_length = data;
      end
      @(posedge clock);
   endtask

   task automatic write_config(input logic [1:0] mode, input logic [LBITS-1:0] len);
      logic [LBITS-1:0] data;
      wait_idle(SETTLE);
      // upper bits of the mode word are don't-care
      data      = LBITS'($urandom);
      data[1:0] = mode;
      write_reg(wtosc_pkg::CSR_FADE_MODE, data);
      write_reg(wtosc_pkg::CSR_FADE_LENGTH, len);
   endtask

   task automatic run_table_update(output int count);
      int n;
      count = 0;
      send_cmd(wtosc_pkg::CMD_BEGIN);
      count++;
      if ($urandom_range(0, 6) == 0) begin
         send_cmd(wtosc_pkg::CMD_BEGIN);
      end
      n = $urandom_range(1, 10);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) begin
            send_tick();
            count++;
         end
         send_write(pick_write_index(), $urandom);
         count++;
      end
      send_cmd(wtosc_pkg::CMD_END);
      count++;
   endtask

   task automatic run_traffic(input int items);
      int sent;
      int r;
      int n;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(0, 99);
         if (r < 8 && !osc_updating) begin
            run_table_update(n);
            sent += n;
         end else if (r < 12 && !osc_updating) begin
            // requests the block drops outside an update
            if (r[0]) begin
               send_write($urandom_range(0, TABLE_LEN - 1), $urandom);
            end else begin
               send_cmd(wtosc_pkg::CMD_END);
            end
         end else begin
            send_tick();
            sent++;
         end
      end
   endtask

   task automatic test_before_load();
      send_request(wtosc_pkg::CMD_TICK, STEP_MAX, '0, '0);
      send_request(wtosc_pkg::CMD_TICK, -STEP_MAX, '1, '1);
      send_write(0, 16'h1234);
      send_cmd(wtosc_pkg::CMD_END);
      send_request(wtosc_pkg::CMD_TICK, '0, '0, '0);
   endtask

   task automatic test_first_load();
      send_cmd(wtosc_pkg::CMD_BEGIN);
      send_cmd(wtosc_pkg::CMD_BEGIN);
      send_write(0, 32767);
      send_write(TABLE_LEN - 1, -32768);
      send_write(1, -1);
      send_tick_to(TABLE_LEN - 1);
      send_cmd(wtosc_pkg::CMD_END);
      send_tick_to(1);
      send_tick_to(0);
      send_tick_to(TABLE_LEN - 1);
   endtask

   task automatic test_linear_fade();
      write_config(wtosc_pkg::FADE_LINEAR, 6);
      send_cmd(wtosc_pkg::CMD_BEGIN);
      send_tick_to(0);
      send_write(0, -32768);
      send_write(TABLE_LEN - 1, 32767);
      send_write(1, 0);
      send_cmd(wtosc_pkg::CMD_END);
      repeat (8) send_tick();
   endtask

   // equal banks at full scale push the power sum past the sample range
   task automatic test_power_fade();
      write_config(wtosc_pkg::FADE_POWER, 5);
      send_cmd(wtosc_pkg::CMD_BEGIN);
      send_write(0, -32768);
      send_write(TABLE_LEN - 1, 32767);
      send_write(1, -20000);
      send_cmd(wtosc_pkg::CMD_END);
      send_tick_to(TABLE_LEN - 1);
      send_tick_to(0);
      send_tick_to(1);
      send_tick_to(TABLE_LEN - 1);
      send_tick_to(0);
      send_tick();
   endtask

   task automatic test_fade_switch();
      write_config(wtosc_pkg::FADE_LINEAR, 12);
      send_cmd(wtosc_pkg::CMD_BEGIN);
      send_cmd(wtosc_pkg::CMD_END);
      repeat (2) send_tick();
      write_config(wtosc_pkg::FADE_NONE, 12);
      repeat (2) send_tick();
      write_config(FADE_CODE3, 0);
      send_tick();
      // length below the count: fraction pinned at one
      write_config(wtosc_pkg::FADE_LINEAR, 0);
      send_tick();
      write_config(wtosc_pkg::FADE_POWER, 2);
      send_tick();
      write_config(wtosc_pkg::FADE_POWER, LEN_MAX);
      repeat (2) send_tick();
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      repeat (12) send_tick();
      wait_idle(SETTLE);
   endtask

   task automatic phase_setting(input int p, output logic [1:0] mode,
                                output logic [LBITS-1:0] len);
      case (p)
         0:       begin mode = wtosc_pkg::FADE_LINEAR; len = 16;      end
         1:       begin mode = wtosc_pkg::FADE_POWER;  len = 24;      end
         2:       begin mode = wtosc_pkg::FADE_NONE;   len = 10;      end
         3:       begin mode = FADE_CODE3;             len = 7;       end
         4:       begin mode = wtosc_pkg::FADE_LINEAR; len = 0;       end
         5:       begin mode = wtosc_pkg::FADE_POWER;  len = 1;       end
         6:       begin mode = wtosc_pkg::FADE_LINEAR; len = LEN_MAX; end
         default: begin mode = wtosc_pkg::FADE_POWER;  len = 48000;   end
      endcase
   endtask

   task automatic test_random_traffic();
      logic [1:0]       mode;
      logic [LBITS-1:0] len;
      int               r;
      for (int p = 0; p < 8; p++) begin
         phase_setting(p, mode, len);
         write_config(mode, len);
         tx_burst = ($urandom_range(0, 3) == 0);
         rx_burst = ($urandom_range(0, 3) == 0);
         run_traffic(45);
         // change settings while a fade may still be running
         r = $urandom_range(0, 3);
         if (r == 0) begin
            len = '0;
         end else if (r == 1) begin
            len = LEN_MAX;
         end else begin
            len = LBITS'($urandom_range(1, 40));
         end
         write_config(2'($urandom_range(0, 3)), len);
         run_traffic(45);
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
   endtask

   // response side: random stalls, plus a long hold when asked
   initial begin
      int stall;
      int r;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (rx_burst) begin
            rsp_ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               stall = $urandom_range(8, 40);
            end
            rsp_ready <= (r >= 25);
         end
      end
   end

   initial begin
      logic signed [SBITS-1:0] want;
      int                      sample_no;
      sample_no = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (pending_samples.size() == 0) begin
               flag_mismatch($sformatf("sample %0d with none expected: %0d",
                                       sample_no, rsp_sample));
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample !== want) begin
                  flag_mismatch($sformatf("sample %0d: got %0d, want %0d",
                                          sample_no, rsp_sample, want));
               end
            end
            sample_no++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = wtosc_pkg::CMD_TICK;
      req_phase_step  = '0;
      req_entry_index = '0;
      req_entry_value = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = wtosc_pkg::CSR_FADE_MODE;
      csr_wdata       = '0;
      mismatches      = 0;
      hold_cycles     = 0;
      tx_burst        = 1'b0;
      rx_burst        = 1'b0;
      osc_active      = 0;
      osc_updating    = 1'b0;
      osc_loaded      = 1'b0;
      osc_phase       = '0;
      osc_count       = '0;
      cfg_mode        = wtosc_pkg::FADE_MODE_RESET;
      cfg_length      = wtosc_pkg::FADE_LENGTH_RESET;
      for (int k = 0; k < ROM_LEN; k++) begin
         sine_rom[k] = quarter_sine(k);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_before_load();
      test_first_load();
      test_linear_fade();
      test_power_fade();
      test_fade_switch();
      test_backpressure();
      test_random_traffic();

      wait_idle(64);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* wavetable_oscillator_crossfade_top.f */
hw/rtl/wtosc_pkg.sv
hw/rtl/wtosc_ram.sv
hw/rtl/wtosc_sine_rom.sv
hw/rtl/wtosc_frac_div.sv
hw/rtl/wavetable_oscillator_crossfade_top.sv
dv/wavetable_oscillator_crossfade_top_tb.sv
